/* sv/mafh_pkg.sv */
package mafh_pkg;

    // FNV-1a 32-bit constants
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam int          HASH_W    = 32;

    // Attribute store
    localparam int MAX_ATTR   = 8;
    localparam int ATTR_IDX_W = $clog2(MAX_ATTR);
    localparam int CNT_W      = 4;
    localparam logic [CNT_W-1:0] CNT_MAX  = 4'd15;
    localparam logic [CNT_W-1:0] MAX_ATTR_CNT = 4'(MAX_ATTR);

    // Choice entries: low bits bit position, high bits attribute index
    localparam int NUM_ENTRIES     = 32;
    localparam int POS_W           = 5;
    localparam int ATTR_FIELD_W    = 4;
    localparam int ENTRY_W         = POS_W + ATTR_FIELD_W;
    localparam int ENTRIES_PER_REG = 7;
    localparam int FULL_CHOICE_REGS = 4;
    localparam int CHOICE_W        = ENTRY_W * ENTRIES_PER_REG;
    localparam int LAST_CHOICE_W   = ENTRY_W * (NUM_ENTRIES - FULL_CHOICE_REGS * ENTRIES_PER_REG);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = CHOICE_W;
    localparam int NUM_W      = 4;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ATTR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHOICE_0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHOICE_7  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHOICE_14 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHOICE_21 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHOICE_28 = 3'd5;

    // Count error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_FEWER = 2'd1;
    localparam logic [1:0] ERR_MORE  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_attribute;
        logic       end_of_tuple;
    } item_t;

    typedef struct packed {
        logic [CNT_W-1:0]                         eff_count;
        logic [NUM_ENTRIES-1:0][ENTRY_W-1:0]      choice;
    } cfg_t;

    typedef struct packed {
        logic [MAX_ATTR-1:0][HASH_W-1:0] hashes;
        logic [1:0]                      count_error;
    } snap_t;

    // One FNV-1a byte step; the prime 0x01000193 is applied as shift-add
    function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] hash,
                                                   input logic [7:0] data);
        logic [HASH_W-1:0] x;
        x = hash ^ {24'd0, data};
        return {x[7:0], 24'd0} + {x[23:0], 8'd0} + {x[24:0], 7'd0}
             + {x[27:0], 4'd0} + {x[30:0], 1'd0} + x;
    endfunction

endpackage

/* sv/multi_attribute_fnv_bit_select_hash_top.sv */
// Channel  Direction  Accepted when              Contents
// s_axis   in         s_tvalid && s_tready       one attribute byte with marks
// m_axis   out        m_tvalid && m_tready       tuple hash and count error
// cfg      in         cfg_we                     register cfg_index <= cfg_wdata
//
// One item per cycle is taken while s_tready is high; the running hash update
// is a single shift-add FNV step between the input register and the tuple state.
// A tuple result passes from its last accepted item through the input register,
// the snapshot register and the result register.
// Reset sets the hashes to the offset basis and clears the count and flag at once; no clearing pass.
// A stall on m_axis backs up through the snapshot stage; items that do not
// end a tuple keep flowing until a tuple end sits in the input register while
// the snapshot and result registers both hold results.
module multi_attribute_fnv_bit_select_hash_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] data_byte
    input  logic [1:0]                       s_tuser,   // [0] has_byte, [1] end_of_attribute
    input  logic                             s_tlast,   // end_of_tuple
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata,   // [31:0] tuple_hash
    output logic [1:0]                       m_tuser,   // [1:0] count_error
    input  logic                             cfg_we,
    input  logic [mafh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mafh_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    logic [mafh_pkg::NUM_W-1:0]                  num_attr_reg;
    logic [mafh_pkg::FULL_CHOICE_REGS-1:0][mafh_pkg::CHOICE_W-1:0] choice_reg;
    logic [mafh_pkg::LAST_CHOICE_W-1:0]          choice_last_reg;
    mafh_pkg::cfg_t                              cfg;
    mafh_pkg::item_t                             in_item;
    mafh_pkg::snap_t                             snap;
    logic                                        snap_valid;
    logic                                        snap_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_attr_reg    <= 4'd1;
            choice_reg      <= '0;
            choice_last_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mafh_pkg::REG_NUM_ATTR:  num_attr_reg    <= cfg_wdata[mafh_pkg::NUM_W-1:0];
                mafh_pkg::REG_CHOICE_0:  choice_reg[0]   <= cfg_wdata;
                mafh_pkg::REG_CHOICE_7:  choice_reg[1]   <= cfg_wdata;
                mafh_pkg::REG_CHOICE_14: choice_reg[2]   <= cfg_wdata;
                mafh_pkg::REG_CHOICE_21: choice_reg[3]   <= cfg_wdata;
                mafh_pkg::REG_CHOICE_28: choice_last_reg <= cfg_wdata[mafh_pkg::LAST_CHOICE_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturate the attribute count to the store depth
    assign cfg.eff_count = (num_attr_reg > mafh_pkg::MAX_ATTR_CNT) ?
                           mafh_pkg::MAX_ATTR_CNT : num_attr_reg;

    // Unpack the choice entries
    for (genvar k = 0; k < mafh_pkg::NUM_ENTRIES; k++)
    begin : g_entry
        localparam int R   = k / mafh_pkg::ENTRIES_PER_REG;
        localparam int OFF = (k % mafh_pkg::ENTRIES_PER_REG) * mafh_pkg::ENTRY_W;
        if (R < mafh_pkg::FULL_CHOICE_REGS)
        begin : g_full
            assign cfg.choice[k] = choice_reg[R][OFF +: mafh_pkg::ENTRY_W];
        end
        else
        begin : g_last
            assign cfg.choice[k] = choice_last_reg[OFF +: mafh_pkg::ENTRY_W];
        end
    end

    assign in_item.data_byte        = s_tdata;
    assign in_item.has_byte         = s_tuser[0];
    assign in_item.end_of_attribute = s_tuser[1];
    assign in_item.end_of_tuple     = s_tlast;

    mafh_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap)
    );

    mafh_gather u_gather (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .snap_valid  (snap_valid),
        .snap_ready  (snap_ready),
        .snap        (snap),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .tuple_hash  (m_tdata),
        .count_error (m_tuser)
    );

endmodule

/* sv/mafh_accum.sv */
module mafh_accum (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mafh_pkg::cfg_t        cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  mafh_pkg::item_t       in_item,
    output logic                  snap_valid,
    input  logic                  snap_ready,
    output mafh_pkg::snap_t       snap
);

    logic                                       item_valid_reg;
    mafh_pkg::item_t                            item_reg;
    logic [mafh_pkg::HASH_W-1:0]                run_hash_reg;
    logic [mafh_pkg::HASH_W-1:0]                run_hash_next;
    logic [mafh_pkg::MAX_ATTR-1:0][mafh_pkg::HASH_W-1:0] attr_hash_reg;
    logic [mafh_pkg::MAX_ATTR-1:0][mafh_pkg::HASH_W-1:0] attr_hash_next;
    logic [mafh_pkg::CNT_W-1:0]                 count_reg;
    logic [mafh_pkg::CNT_W-1:0]                 count_next;
    logic                                       overflow_reg;
    logic                                       overflow_next;
    logic [mafh_pkg::HASH_W-1:0]                byte_hash;
    logic                                       finish;
    logic                                       advance;

    // Move the held item on unless it closes a tuple and the snapshot stage is full
    assign advance  = item_valid_reg && (!item_reg.end_of_tuple || snap_ready);
    assign in_ready = !item_valid_reg || advance;
    assign finish   = item_reg.end_of_attribute || item_reg.end_of_tuple;

    // Hash the byte and close the attribute
    always_comb
    begin
        byte_hash      = item_reg.has_byte ?
                         mafh_pkg::fnv_step(run_hash_reg, item_reg.data_byte) : run_hash_reg;
        run_hash_next  = byte_hash;
        attr_hash_next = attr_hash_reg;
        count_next     = count_reg;
        overflow_next  = overflow_reg;
        if (finish)
        begin
            if (count_reg < cfg.eff_count)
                attr_hash_next[count_reg[mafh_pkg::ATTR_IDX_W-1:0]] = byte_hash;
            else
                overflow_next = 1'b1;
            if (count_reg < mafh_pkg::CNT_MAX)
                count_next = count_reg + 1'b1;
            run_hash_next = mafh_pkg::FNV_BASIS;
        end
    end

    // Snapshot of the finished tuple
    always_comb
    begin
        snap.hashes = attr_hash_next;
        if (overflow_next)
            snap.count_error = mafh_pkg::ERR_MORE;
        else if (count_next < cfg.eff_count)
            snap.count_error = mafh_pkg::ERR_FEWER;
        else
            snap.count_error = mafh_pkg::ERR_NONE;
    end
    assign snap_valid = item_valid_reg && item_reg.end_of_tuple;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= in_item;
    end

    // Tuple state; clear on tuple end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_hash_reg  <= mafh_pkg::FNV_BASIS;
            attr_hash_reg <= {mafh_pkg::MAX_ATTR{mafh_pkg::FNV_BASIS}};
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
        end
        else if (advance)
        begin
            if (item_reg.end_of_tuple)
            begin
                run_hash_reg  <= mafh_pkg::FNV_BASIS;
                attr_hash_reg <= {mafh_pkg::MAX_ATTR{mafh_pkg::FNV_BASIS}};
                count_reg     <= '0;
                overflow_reg  <= 1'b0;
            end
            else
            begin
                run_hash_reg  <= run_hash_next;
                attr_hash_reg <= attr_hash_next;
                count_reg     <= count_next;
                overflow_reg  <= overflow_next;
            end
        end
    end

endmodule

/* sv/mafh_gather.sv */
module mafh_gather (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mafh_pkg::cfg_t               cfg,
    input  logic                         snap_valid,
    output logic                         snap_ready,
    input  mafh_pkg::snap_t              snap,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [mafh_pkg::HASH_W-1:0]  tuple_hash,
    output logic [1:0]                   count_error
);

    logic                         snap_valid_reg;
    mafh_pkg::snap_t              snap_reg;
    logic                         out_valid_reg;
    logic [mafh_pkg::HASH_W-1:0]  hash_reg;
    logic [1:0]                   err_reg;
    logic [mafh_pkg::HASH_W-1:0]  hash_next;
    logic                         out_free;
    logic                         snap_adv;

    assign out_free   = !out_valid_reg || out_ready;
    assign snap_adv   = snap_valid_reg && out_free;
    assign snap_ready = !snap_valid_reg || snap_adv;

    // Pick one hash bit per choice entry
    always_comb
    begin
        logic [mafh_pkg::ENTRY_W-1:0]      e;
        logic [mafh_pkg::POS_W-1:0]        pos;
        logic [mafh_pkg::ATTR_FIELD_W-1:0] attr;
        for (int k = 0; k < mafh_pkg::NUM_ENTRIES; k++)
        begin
            e    = cfg.choice[k];
            pos  = e[mafh_pkg::POS_W-1:0];
            attr = e[mafh_pkg::ENTRY_W-1:mafh_pkg::POS_W];
            if (attr < cfg.eff_count)
                hash_next[k] = snap_reg.hashes[attr[mafh_pkg::ATTR_IDX_W-1:0]][pos];
            else
                hash_next[k] = 1'b0;
        end
    end

    // Snapshot register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            snap_valid_reg <= 1'b0;
        else if (snap_ready)
            snap_valid_reg <= snap_valid;
    end

    always_ff @(posedge clk)
    begin
        if (snap_ready && snap_valid)
            snap_reg <= snap;
    end

    // Result register; hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= snap_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (snap_adv)
        begin
            hash_reg <= hash_next;
            err_reg  <= snap_reg.count_error;
        end
    end

    assign out_valid   = out_valid_reg;
    assign tuple_hash  = hash_reg;
    assign count_error = err_reg;

endmodule

/* sv/mafh_checker.sv */
module mafh_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [1:0]  m_tuser
);

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Count error code is never the unused value
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser != 2'b11)
        else $error("bad count error code");

    // With the output free, the input side never stalls
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with output empty");

    // An accepted tuple end is followed by a result on m_tvalid
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |-> ##3 m_tvalid)
        else $error("tuple result missing");

endmodule

bind multi_attribute_fnv_bit_select_hash_top mafh_checker u_mafh_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* verif/fnv_tuple_checker.sv */
`timescale 1ns / 1ps

module fnv_tuple_checker
    import mafh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic [1:0]            s_tuser,   // [0] has_byte, [1] end_of_attribute
    input  logic                  s_tlast,   // end_of_tuple
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [31:0]           m_tdata,   // [31:0] tuple_hash
    input  logic [1:0]            m_tuser,   // [1:0] count_error
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    pending,
    output int                    fail_count
);

    typedef struct {
        logic [HASH_W-1:0] tuple_hash;
        logic [1:0]        count_error;
    } tuple_result_t;

    // Mirrored registers
    logic [NUM_W-1:0]      num_attr_q;
    logic [CFG_DATA_W-1:0] choice_q [FULL_CHOICE_REGS+1];

    // Tuple state
    logic [HASH_W-1:0] open_hash;
    logic [HASH_W-1:0] stored_hash [MAX_ATTR];
    logic [CNT_W-1:0]  attr_seen;
    logic              extra_seen;

    tuple_result_t tuple_results_q [$];

    function automatic logic [CNT_W-1:0] active_attrs();
        return (num_attr_q > MAX_ATTR_CNT) ? MAX_ATTR_CNT : num_attr_q;
    endfunction

    task automatic restart_tuple();
        int i;
        open_hash = FNV_BASIS;
        for (i = 0; i < MAX_ATTR; i++)
            stored_hash[i] = FNV_BASIS;
        attr_seen  = '0;
        extra_seen = 1'b0;
    endtask

    // Store the running hash under its position, or flag an extra attribute
    task automatic close_attribute();
        if (attr_seen < active_attrs())
            stored_hash[attr_seen[ATTR_IDX_W-1:0]] = open_hash;
        else
            extra_seen = 1'b1;
        if (attr_seen != CNT_MAX)
            attr_seen = attr_seen + 1'b1;
        open_hash = FNV_BASIS;
    endtask

    // Pick one bit per choice entry from the stored attribute hashes
    function automatic logic [HASH_W-1:0] gather_bits();
        logic [HASH_W-1:0]       h;
        logic [ENTRY_W-1:0]      e;
        logic [POS_W-1:0]        pos;
        logic [ATTR_FIELD_W-1:0] attr;
        int                      k;
        h = '0;
        for (k = 0; k < NUM_ENTRIES; k++) begin
            e    = ENTRY_W'(choice_q[k / ENTRIES_PER_REG] >> (ENTRY_W * (k % ENTRIES_PER_REG)));
            pos  = e[POS_W-1:0];
            attr = e[ENTRY_W-1:POS_W];
            if (attr < active_attrs())
                h[k] = stored_hash[attr[ATTR_IDX_W-1:0]][pos];
        end
        return h;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tuple_result_t want;
        if (!rst_n)
        begin
            num_attr_q = 4'd1;
            for (int r = 0; r <= FULL_CHOICE_REGS; r++)
                choice_q[r] = '0;
            restart_tuple();
            tuple_results_q.delete();
            fail_count = 0;
        end
        else
        begin
            // Compare a delivered result with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                if (tuple_results_q.size() == 0)
                begin
                    $error("result item with no prediction waiting: tuple_hash %h count_error %0d",
                           m_tdata, m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = tuple_results_q.pop_front();
                    if (m_tdata !== want.tuple_hash)
                    begin
                        $error("tuple_hash: expected %h, actual %h", want.tuple_hash, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser !== want.count_error)
                    begin
                        $error("count_error: expected %0d, actual %0d",
                               want.count_error, m_tuser);
                        fail_count++;
                    end
                end
            end

            // Track register writes; unknown indexes are dropped
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NUM_ATTR:  num_attr_q  = cfg_wdata[NUM_W-1:0];
                    REG_CHOICE_0:  choice_q[0] = cfg_wdata;
                    REG_CHOICE_7:  choice_q[1] = cfg_wdata;
                    REG_CHOICE_14: choice_q[2] = cfg_wdata;
                    REG_CHOICE_21: choice_q[3] = cfg_wdata;
                    REG_CHOICE_28: choice_q[4] = CFG_DATA_W'(cfg_wdata[LAST_CHOICE_W-1:0]);
                    default: ;
                endcase
            end

            // Advance the tuple state on each accepted item
            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0])
                    open_hash = (open_hash ^ {24'd0, s_tdata}) * FNV_PRIME;
                if (s_tuser[1] || s_tlast)
                    close_attribute();
                if (s_tlast)
                begin
                    want.tuple_hash = gather_bits();
                    if (extra_seen)
                        want.count_error = ERR_MORE;
                    else if (attr_seen < active_attrs())
                        want.count_error = ERR_FEWER;
                    else
                        want.count_error = ERR_NONE;
                    tuple_results_q.push_back(want);
                    restart_tuple();
                end
            end
        end
        pending = tuple_results_q.size();
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
    import mafh_pkg::*;

    // Indexes outside the register map; writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam int ITEM_TARGET  = 800;
    localparam int PHASE_ITEMS  = 90;
    localparam int SETTLE_TICKS = 8;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic [1:0]            s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [31:0]           m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int   pending;
    int   fail_count;
    int   items_sent;
    int   active_cnt;
    logic calm;

    always #5 clk = ~clk;

    multi_attribute_fnv_bit_select_hash_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    fnv_tuple_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .pending    (pending),
        .fail_count (fail_count)
    );

    function automatic logic [CFG_DATA_W-1:0] junk_word();
        return CFG_DATA_W'({$urandom, $urandom});
    endfunction

    // Pack choice entries; diagonal picks bit k of attribute k mod 8
    function automatic logic [CFG_DATA_W-1:0] pack_entries(input int first, input int count,
                                                          input bit diagonal);
        logic [CFG_DATA_W-1:0]   w;
        logic [POS_W-1:0]        pos;
        logic [ATTR_FIELD_W-1:0] attr;
        int                      j;
        w = '0;
        for (j = 0; j < count; j++) begin
            if (diagonal) begin
                pos  = POS_W'(first + j);
                attr = ATTR_FIELD_W'((first + j) % MAX_ATTR);
            end
            else begin
                pos  = POS_W'($urandom_range(0, 31));
                attr = ($urandom_range(0, 3) == 0) ? ATTR_FIELD_W'($urandom_range(0, 15))
                                                   : ATTR_FIELD_W'($urandom_range(0, 7));
            end
            w = w | (CFG_DATA_W'({attr, pos}) << (ENTRY_W * j));
        end
        return w;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Write the attribute count with junk above its four bits
    task automatic set_attr_count(input int n);
        logic [CFG_DATA_W-1:0] w;
        w = junk_word();
        w[NUM_W-1:0] = NUM_W'(n);
        write_reg(REG_NUM_ATTR, w);
        active_cnt = (n > MAX_ATTR) ? MAX_ATTR : n;
    endtask

    // Load all five choice registers; the last one gets junk above its width
    task automatic set_choices(input bit diagonal);
        logic [CFG_DATA_W-1:0] w;
        write_reg(REG_CHOICE_0,  pack_entries(0,  ENTRIES_PER_REG, diagonal));
        write_reg(REG_CHOICE_7,  pack_entries(7,  ENTRIES_PER_REG, diagonal));
        write_reg(REG_CHOICE_14, pack_entries(14, ENTRIES_PER_REG, diagonal));
        write_reg(REG_CHOICE_21, pack_entries(21, ENTRIES_PER_REG, diagonal));
        w = junk_word();
        w[LAST_CHOICE_W-1:0] = LAST_CHOICE_W'(pack_entries(28, NUM_ENTRIES - 28, diagonal));
        write_reg(REG_CHOICE_28, w);
    endtask

    // Hold off until every tuple result is out and the pipeline has drained
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    task automatic send_item(input logic [7:0] d, input logic hb, input logic eoa,
                             input logic eot);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            s_tdata  = 8'($urandom);
            s_tuser  = 2'($urandom);
            s_tlast  = 1'($urandom);
            repeat (gap) @(negedge clk);
        end
        s_tdata  = d;
        s_tuser  = {eoa, hb};
        s_tlast  = eot;
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        if (hb || eoa || eot)
            items_sent++;
    endtask

    // One tuple of n_attr attributes; trail_eot closes with a bare tuple end
    task automatic send_tuple(input int n_attr, input bit trail_eot);
        int a;
        int b;
        int len;
        bit last;
        bit tail;
        for (a = 0; a < n_attr; a++) begin
            last = (a == n_attr - 1) && !trail_eot;
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
            for (b = 0; b < len; b++) begin
                if ($urandom_range(0, 15) == 0)
                    send_item(8'($urandom), 1'b0, 1'b0, 1'b0);
                tail = (b == len - 1);
                send_item(8'($urandom), 1'b1, tail && (!last || $urandom_range(0, 1) == 1),
                          tail && last);
            end
            if (len == 0)
                send_item(8'($urandom), 1'b0, !last || $urandom_range(0, 1) == 1, last);
        end
        if (trail_eot)
            send_item(8'($urandom), 1'b0, 1'b0, 1'b1);
    endtask

    // Attribute count per tuple: mostly matched, some short, long or saturating
    function automatic int pick_attr_count();
        int r;
        int base;
        r    = $urandom_range(0, 19);
        base = (active_cnt == 0) ? 1 : active_cnt;
        if (r < 12)
            return base;
        else if (r < 14)
            return base + 1;
        else if (r < 16)
            return (base > 1) ? base - 1 : 1;
        else if (r < 19)
            return $urandom_range(1, 10);
        else
            return $urandom_range(15, 18);
    endfunction

    // Result side: random stalls per item, none while calm
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 7);
            if (gap != 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
            @(negedge clk);
        end
    end

    // Stimulus and verdict
    initial
    begin
        int phase;
        int n;
        int phase_start;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        s_tlast    = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_NUM_ATTR;
        cfg_wdata  = '0;
        items_sent = 0;
        active_cnt = 1;
        calm       = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset settings: every output bit is bit 0 of the first attribute
        send_item(8'hFF, 1'b1, 1'b1, 1'b1);
        send_item(8'h00, 1'b0, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0, 1'b1);
        send_item(8'h5A, 1'b0, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b0, 1'b0);
        send_item(8'h01, 1'b1, 1'b1, 1'b1);

        // Full count, diagonal picks: short tuple with an empty attribute
        wait_idle();
        set_attr_count(MAX_ATTR);
        set_choices(1'b1);
        write_reg(REG_SPARE_6, junk_word());
        write_reg(REG_SPARE_7, junk_word());
        send_item(8'hAA, 1'b1, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1, 1'b0);
        send_item(8'h55, 1'b1, 1'b0, 1'b1);

        // Zero count: hash is zero and every attribute is extra
        wait_idle();
        set_attr_count(0);
        send_item(8'hFF, 1'b1, 1'b1, 1'b1);
        send_item(8'h7F, 1'b1, 1'b0, 1'b1);

        // Count above the store saturates; all-ones picks point past it
        wait_idle();
        set_attr_count(15);
        write_reg(REG_CHOICE_0,  '1);
        write_reg(REG_CHOICE_7,  '1);
        write_reg(REG_CHOICE_14, '1);
        write_reg(REG_CHOICE_21, '1);
        write_reg(REG_CHOICE_28, '1);
        send_item(8'h01, 1'b1, 1'b0, 1'b1);
        send_tuple(MAX_ATTR, 1'b0);

        // Random phases, each ending on a tuple boundary
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            wait_idle();
            case (phase % 6)
                0:       n = 1;
                1:       n = MAX_ATTR;
                2:       n = 0;
                3:       n = 15;
                default: n = $urandom_range(0, 15);
            endcase
            set_attr_count(n);
            set_choices(1'b0);
            if (phase % 7 == 3)
                write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_6 : REG_SPARE_7, junk_word());
            calm = (phase % 4 == 2);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                send_tuple(pick_attr_count(), $urandom_range(0, 9) == 0);
            calm = 1'b0;
            phase++;
        end

        // Drain and let the pipeline settle before the verdict
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4 * SETTLE_TICKS) @(negedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
sv/mafh_pkg.sv
sv/mafh_accum.sv
sv/mafh_gather.sv
sv/multi_attribute_fnv_bit_select_hash_top.sv
sv/mafh_checker.sv
verif/fnv_tuple_checker.sv
verif/tb.sv
